@@ hw/rtl/mte_pkg.sv @@
package mte_pkg;

	// token kinds carried in s_tuser[3:0]
	localparam logic [3:0] FUNC_NIL     = 4'd0;
	localparam logic [3:0] FUNC_BOOL    = 4'd1;
	localparam logic [3:0] FUNC_INT     = 4'd2;
	localparam logic [3:0] FUNC_DOUBLE  = 4'd3;
	localparam logic [3:0] FUNC_STR     = 4'd4;
	localparam logic [3:0] FUNC_BIN     = 4'd5;
	localparam logic [3:0] FUNC_ARRAY   = 4'd6;
	localparam logic [3:0] FUNC_MAP     = 4'd7;
	localparam logic [3:0] FUNC_PAYLOAD = 4'd8;

	// msgpack lead bytes
	localparam logic [7:0] OP_NIL     = 8'hC0;
	localparam logic [7:0] OP_FALSE   = 8'hC2;
	localparam logic [7:0] OP_TRUE    = 8'hC3;
	localparam logic [7:0] OP_BIN8    = 8'hC4;
	localparam logic [7:0] OP_BIN16   = 8'hC5;
	localparam logic [7:0] OP_BIN32   = 8'hC6;
	localparam logic [7:0] OP_FLOAT64 = 8'hCB;
	localparam logic [7:0] OP_UINT8   = 8'hCC;
	localparam logic [7:0] OP_UINT16  = 8'hCD;
	localparam logic [7:0] OP_UINT32  = 8'hCE;
	localparam logic [7:0] OP_UINT64  = 8'hCF;
	localparam logic [7:0] OP_INT8    = 8'hD0;
	localparam logic [7:0] OP_INT16   = 8'hD1;
	localparam logic [7:0] OP_INT32   = 8'hD2;
	localparam logic [7:0] OP_INT64   = 8'hD3;
	localparam logic [7:0] OP_STR8    = 8'hD9;
	localparam logic [7:0] OP_STR16   = 8'hDA;
	localparam logic [7:0] OP_STR32   = 8'hDB;
	localparam logic [7:0] OP_ARR16   = 8'hDC;
	localparam logic [7:0] OP_ARR32   = 8'hDD;
	localparam logic [7:0] OP_MAP16   = 8'hDE;
	localparam logic [7:0] OP_MAP32   = 8'hDF;
	localparam logic [7:0] OP_FIXSTR  = 8'hA0;
	localparam logic [7:0] OP_FIXARR  = 8'h90;
	localparam logic [7:0] OP_FIXMAP  = 8'h80;

	// stream widths
	localparam int TDATA_W = 168;
	localparam int TUSER_W = 5;

	localparam int QUEUE_DEPTH_DEF = 4;

	// one classified token: lead byte, then nbytes big-endian bytes of value
	typedef struct packed {
		logic [7:0]  head;
		logic [3:0]  nbytes;
		logic [63:0] value;
	} tok_desc_t;

	typedef struct packed {
		logic      valid;
		tok_desc_t desc;
	} q_head_t;

endpackage

@@ hw/rtl/mte_front.sv @@
module mte_front import mte_pkg::*; (
	input  logic [3:0]  func,
	input  logic        flag,
	input  logic [63:0] int_value,
	input  logic [63:0] float_bits,
	input  logic [31:0] count,
	input  logic [7:0]  data_byte,
	output logic        tok_valid,
	output tok_desc_t   tok_desc
);

	logic neg;
	logic [63:0] cnt64;

	assign neg   = int_value[63];
	assign cnt64 = {32'd0, count};

	always_comb begin
		tok_valid       = 1'b1;
		tok_desc.head   = OP_NIL;
		tok_desc.nbytes = 4'd0;
		tok_desc.value  = int_value;
		case (func)
			FUNC_NIL: begin
				tok_desc.head = OP_NIL;
			end
			FUNC_BOOL: begin
				tok_desc.head = flag ? OP_TRUE : OP_FALSE;
			end
			FUNC_INT: begin
				if (!neg) begin
					if (int_value[63:7] == '0) begin
						tok_desc.head = int_value[7:0];
					end else if (int_value[63:8] == '0) begin
						tok_desc.head = OP_UINT8;  tok_desc.nbytes = 4'd1;
					end else if (int_value[63:16] == '0) begin
						tok_desc.head = OP_UINT16; tok_desc.nbytes = 4'd2;
					end else if (int_value[63:32] == '0) begin
						tok_desc.head = OP_UINT32; tok_desc.nbytes = 4'd4;
					end else begin
						tok_desc.head = OP_UINT64; tok_desc.nbytes = 4'd8;
					end
				end else begin
					// negative fixint: top three bits already ones
					if (&int_value[63:5]) begin
						tok_desc.head = int_value[7:0];
					end else if (&int_value[63:7]) begin
						tok_desc.head = OP_INT8;  tok_desc.nbytes = 4'd1;
					end else if (&int_value[63:15]) begin
						tok_desc.head = OP_INT16; tok_desc.nbytes = 4'd2;
					end else if (&int_value[63:31]) begin
						tok_desc.head = OP_INT32; tok_desc.nbytes = 4'd4;
					end else begin
						tok_desc.head = OP_INT64; tok_desc.nbytes = 4'd8;
					end
				end
			end
			FUNC_DOUBLE: begin
				tok_desc.head   = OP_FLOAT64;
				tok_desc.nbytes = 4'd8;
				tok_desc.value  = float_bits;
			end
			FUNC_STR: begin
				tok_desc.value = cnt64;
				if (count[31:5] == '0) begin
					tok_desc.head = OP_FIXSTR | {3'd0, count[4:0]};
				end else if (count[31:8] == '0) begin
					tok_desc.head = OP_STR8;  tok_desc.nbytes = 4'd1;
				end else if (count[31:16] == '0) begin
					tok_desc.head = OP_STR16; tok_desc.nbytes = 4'd2;
				end else begin
					tok_desc.head = OP_STR32; tok_desc.nbytes = 4'd4;
				end
			end
			FUNC_BIN: begin
				tok_desc.value = cnt64;
				if (count[31:8] == '0) begin
					tok_desc.head = OP_BIN8;  tok_desc.nbytes = 4'd1;
				end else if (count[31:16] == '0) begin
					tok_desc.head = OP_BIN16; tok_desc.nbytes = 4'd2;
				end else begin
					tok_desc.head = OP_BIN32; tok_desc.nbytes = 4'd4;
				end
			end
			FUNC_ARRAY, FUNC_MAP: begin
				tok_desc.value = cnt64;
				if (count[31:4] == '0) begin
					tok_desc.head = ((func == FUNC_MAP) ? OP_FIXMAP : OP_FIXARR)
						| {4'd0, count[3:0]};
				end else if (count[31:16] == '0) begin
					tok_desc.head   = (func == FUNC_MAP) ? OP_MAP16 : OP_ARR16;
					tok_desc.nbytes = 4'd2;
				end else begin
					tok_desc.head   = (func == FUNC_MAP) ? OP_MAP32 : OP_ARR32;
					tok_desc.nbytes = 4'd4;
				end
			end
			FUNC_PAYLOAD: begin
				tok_desc.head = data_byte;
			end
			default: begin
				// unused kinds are dropped
				tok_valid = 1'b0;
			end
		endcase
	end

endmodule

@@ hw/rtl/mte_queue.sv @@
module mte_queue import mte_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tok_desc_t push_desc,
	output logic      full,
	output q_head_t   head,
	input  logic      pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tok_desc_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head.valid = (cnt_q != '0);
	assign head.desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/mte_back.sv @@
module mte_back import mte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output logic       pop,
	output logic [3:0] byte_idx,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [3:0] idx_q;
	logic       load, fire, last;
	logic [2:0] sel;
	logic [7:0] cur_byte;

	assign load = !out_valid_q || m_tready;
	assign fire = load && head.valid;
	assign last = (idx_q == head.desc.nbytes);
	assign pop  = fire && last;

	// byte k of an n-byte field sits at byte lane n-k of value
	assign sel      = 3'(head.desc.nbytes - idx_q);
	assign cur_byte = (idx_q == '0) ? head.desc.head : head.desc.value[{sel, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= head.valid;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (fire) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= cur_byte;
			out_last_q <= last;
		end
	end

	assign byte_idx = idx_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

@@ hw/rtl/msgpack_token_encoder_unit.sv @@
// msgpack token encoder.
// Slave stream: one value token per item. s_tuser carries the kind (func) and
// the bool flag; s_tdata carries int_value, float_bits, count and data_byte.
// Master stream: one encoded byte per item on m_tdata, m_tlast set on the
// final byte of each token. Unused kinds produce no bytes at all.
// Front end classifies a token in the accepting cycle (lead byte plus 0, 1,
// 2, 4 or 8 big-endian value bytes) and writes it into a small queue; the
// back end serialises the queue head into an output register.
// A token is first written into the queue; its lead byte is then loaded
// into the output register, where the receiver takes it from m_tdata.
// Throughput: one output byte per cycle while m_tready is high; a token holds
// the serialiser for all its bytes (1 for payload/nil/bool/fixints, up to 9
// for 64-bit ints and doubles), so payload streams at one item per cycle.
// s_tready is high whenever the queue has room, independent of the output.
// Reset empties the queue and clears m_tvalid.
// Receiver stall: m_tdata/m_tlast hold, the serialiser waits, and input is
// still taken until QUEUE_DEPTH tokens are waiting.
module msgpack_token_encoder_unit import mte_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// [63:0] int_value, [127:64] float_bits, [159:128] count,
	// [167:160] data_byte
	input  logic [TDATA_W-1:0] s_tdata,
	// [3:0] func, [4] flag
	input  logic [TUSER_W-1:0] s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] out_byte
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	logic      tok_valid;
	tok_desc_t tok_desc;
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	q_head_t   q_head;
	logic [3:0] byte_idx;

	mte_front u_front (
		.func       (s_tuser[3:0]),
		.flag       (s_tuser[4]),
		.int_value  (s_tdata[63:0]),
		.float_bits (s_tdata[127:64]),
		.count      (s_tdata[159:128]),
		.data_byte  (s_tdata[167:160]),
		.tok_valid  (tok_valid),
		.tok_desc   (tok_desc)
	);

	assign s_tready = !q_full;
	// dropped kinds are accepted but never queued
	assign q_push   = s_tvalid && s_tready && tok_valid;

	mte_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (tok_desc),
		.full      (q_full),
		.head      (q_head),
		.pop       (q_pop)
	);

	mte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.byte_idx (byte_idx),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// serialiser never runs past the head token's byte count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.valid |-> byte_idx <= q_head.desc.nbytes)
		else $error("byte index beyond token length");

	// after a non-final byte leaves, the rest of that token follows at once
	a_token_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap inside a token");

	// payload into an idle block passes queue and output register, marked last
	a_payload_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[3:0] == FUNC_PAYLOAD && !q_head.valid
			&& (!m_tvalid || m_tready))
		|=> ##1 (m_tvalid && m_tlast && m_tdata == $past(s_tdata[167:160], 2)))
		else $error("payload byte not passed through");

endmodule

@@ verif/tb_msgpack_token_encoder_unit.sv @@
`timescale 1ns / 1ps

module tb_msgpack_token_encoder_unit;
	import mte_pkg::*;

	// kinds the block does not decode: no bytes may come out for these
	localparam logic [3:0] FUNC_SPARE_LO = 4'd9;
	localparam logic [3:0] FUNC_SPARE_HI = 4'd15;

	// negative fixint lead bits
	localparam logic [7:0] OP_NEGFIX = 8'hE0;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;	// idle time after the final drain, so stray bytes are still seen
	localparam int RAND_ITEMS = 230;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	// [63:0] int_value, [127:64] float_bits, [159:128] count, [167:160] data_byte
	logic [TDATA_W-1:0] s_tdata = '0;
	// [3:0] func, [4] flag
	logic [TUSER_W-1:0] s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// [7:0] out_byte
	logic [7:0]         m_tdata;
	logic               m_tlast;

	msgpack_token_encoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Encoded-byte predictor
	// ---------------------------------------------------------------
	typedef struct {
		logic [7:0] val;
		logic       tail;	// final byte of its token
	} enc_byte_t;

	enc_byte_t enc_q[$];	// bytes still owed by the block, oldest first

	function automatic void put_byte(input logic [7:0] v);
		enc_byte_t e;
		e.val = v;
		e.tail = 1'b0;
		enc_q = {enc_q, e};
	endfunction

	// big-endian, most significant of nb bytes first
	function automatic void put_be(input logic [63:0] v, input int nb);
		for (int k = nb - 1; k >= 0; k--)
			put_byte(v[k*8 +: 8]);
	endfunction

	// length/count header; tiny_lim of 0 means no fix form, op8 only where has8
	function automatic void put_len(input logic [31:0] n, input logic [7:0] tiny_base,
			input int tiny_lim, input bit has8, input logic [7:0] op8,
			input logic [7:0] op16, input logic [7:0] op32);
		if (n < tiny_lim)
			put_byte(tiny_base | n[7:0]);
		else if (has8 && n <= 32'hFF) begin
			put_byte(op8);
			put_byte(n[7:0]);
		end else if (n <= 32'hFFFF) begin
			put_byte(op16);
			put_be({32'd0, n}, 2);
		end else begin
			put_byte(op32);
			put_be({32'd0, n}, 4);
		end
	endfunction

	// sign decided on bit 63; negative bands compared as raw two's complement
	function automatic void put_int(input logic [63:0] raw);
		if (!raw[63]) begin
			if (raw < 64'h80)
				put_byte(raw[7:0]);
			else if (raw <= 64'hFF) begin
				put_byte(OP_UINT8);
				put_byte(raw[7:0]);
			end else if (raw <= 64'hFFFF) begin
				put_byte(OP_UINT16);
				put_be(raw, 2);
			end else if (raw <= 64'hFFFF_FFFF) begin
				put_byte(OP_UINT32);
				put_be(raw, 4);
			end else begin
				put_byte(OP_UINT64);
				put_be(raw, 8);
			end
		end else begin
			if (raw >= 64'hFFFF_FFFF_FFFF_FFE0)
				put_byte(OP_NEGFIX | {3'b000, raw[4:0]});	// negative fixint
			else if (raw >= 64'hFFFF_FFFF_FFFF_FF80) begin
				put_byte(OP_INT8);
				put_byte(raw[7:0]);
			end else if (raw >= 64'hFFFF_FFFF_FFFF_8000) begin
				put_byte(OP_INT16);
				put_be(raw, 2);
			end else if (raw >= 64'hFFFF_FFFF_8000_0000) begin
				put_byte(OP_INT32);
				put_be(raw, 4);
			end else begin
				put_byte(OP_INT64);
				put_be(raw, 8);
			end
		end
	endfunction

	function automatic void encode_token(input logic [3:0] f, input logic fl,
			input logic [63:0] iv, input logic [63:0] fb, input logic [31:0] c,
			input logic [7:0] db);
		int n0;
		n0 = enc_q.size();
		case (f)
			FUNC_NIL:     put_byte(OP_NIL);
			FUNC_BOOL:    put_byte(fl ? OP_TRUE : OP_FALSE);
			FUNC_INT:     put_int(iv);
			FUNC_DOUBLE: begin
				put_byte(OP_FLOAT64);
				put_be(fb, 8);
			end
			FUNC_STR:     put_len(c, OP_FIXSTR, 32, 1'b1, OP_STR8, OP_STR16, OP_STR32);
			FUNC_BIN:     put_len(c, 8'h00, 0, 1'b1, OP_BIN8, OP_BIN16, OP_BIN32);
			FUNC_ARRAY:   put_len(c, OP_FIXARR, 16, 1'b0, 8'h00, OP_ARR16, OP_ARR32);
			FUNC_MAP:     put_len(c, OP_FIXMAP, 16, 1'b0, 8'h00, OP_MAP16, OP_MAP32);
			FUNC_PAYLOAD: put_byte(db);
			default: ;	// spare kinds: nothing
		endcase
		if (enc_q.size() > n0)
			enc_q[enc_q.size()-1].tail = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them
	// ---------------------------------------------------------------
	int burst_left = 0;

	task automatic drive_item(input logic [3:0] f, input logic fl, input logic [63:0] iv,
			input logic [63:0] fb, input logic [31:0] c, input logic [7:0] db);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= {fl, f};
		s_tdata  <= {db, c, fb, iv};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic issue(input logic [3:0] f, input logic fl, input logic [63:0] iv,
			input logic [63:0] fb, input logic [31:0] c, input logic [7:0] db);
		drive_item(f, fl, iv, fb, c, db);
		encode_token(f, fl, iv, fb, c, db);
	endtask

	// hold the sender off until every owed byte has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (enc_q.size() != 0);
		burst_left = 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// ---------------------------------------------------------------
	// Directed items. Rows with lit_ok carry the bytes typed in, right
	// justified, first byte highest; the rest go through the predictor.
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [3:0]  func;
		logic        flag;
		logic [63:0] ival;
		logic [63:0] fbits;
		logic [31:0] cnt;
		logic [7:0]  dbyte;
		logic        lit_ok;
		logic [3:0]  n_lit;
		logic [71:0] lit;
	} dir_row_t;

	localparam logic [63:0] ONES = '1;
	localparam int N_DIR = 27;

	dir_row_t dir_tbl [N_DIR] = '{
		// nil with every unused field saturated
		'{FUNC_NIL,     1'b1, ONES, ONES, '1, 8'hFF, 1'b1, 4'd1, 72'hC0},
		'{FUNC_BOOL,    1'b0, ONES, ONES, '1, 8'hFF, 1'b1, 4'd1, 72'hC2},
		'{FUNC_BOOL,    1'b1, 64'd0, 64'd0, '0, 8'h00, 1'b1, 4'd1, 72'hC3},
		// positive ints in fixint, uint8, uint32 and uint64 form
		'{FUNC_INT,     1'b1, 64'd0, ONES, '1, 8'hFF, 1'b1, 4'd1, 72'h00},
		'{FUNC_INT,     1'b0, 64'd127, 64'd0, '0, 8'h00, 1'b1, 4'd1, 72'h7F},
		'{FUNC_INT,     1'b0, 64'd128, 64'd0, '0, 8'h00, 1'b1, 4'd2, 72'hCC80},
		'{FUNC_INT,     1'b0, 64'h1_0000, 64'd0, '0, 8'h00, 1'b1, 4'd5, 72'hCE00010000},
		'{FUNC_INT,     1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, '0, 8'h00,
			1'b1, 4'd9, 72'hCF7FFFFFFFFFFFFFFF},
		// negative ints
		'{FUNC_INT,     1'b0, ONES, 64'd0, '0, 8'h00, 1'b1, 4'd1, 72'hFF},
		'{FUNC_INT,     1'b0, -64'sd32, 64'd0, '0, 8'h00, 1'b1, 4'd1, 72'hE0},
		'{FUNC_INT,     1'b0, -64'sd33, 64'd0, '0, 8'h00, 1'b1, 4'd2, 72'hD0DF},
		'{FUNC_INT,     1'b0, -64'sd32768, 64'd0, '0, 8'h00, 1'b1, 4'd3, 72'hD18000},
		'{FUNC_INT,     1'b0, -64'sd2147483649, 64'd0, '0, 8'h00, 1'b0, 4'd0, 72'h0},
		'{FUNC_INT,     1'b0, 64'h8000_0000_0000_0000, 64'd0, '0, 8'h00,
			1'b1, 4'd9, 72'hD38000000000000000},
		// doubles
		'{FUNC_DOUBLE,  1'b0, 64'd0, ONES, '0, 8'h00, 1'b1, 4'd9, 72'hCBFFFFFFFFFFFFFFFF},
		'{FUNC_DOUBLE,  1'b1, ONES, 64'd0, '1, 8'hFF, 1'b0, 4'd0, 72'h0},
		// strings, binaries, arrays, maps, payload; an empty string or binary is its header alone, marked last
		'{FUNC_STR,     1'b0, 64'd0, 64'd0, 32'd0, 8'h00, 1'b1, 4'd1, 72'hA0},
		'{FUNC_STR,     1'b0, 64'd0, 64'd0, 32'd31, 8'h00, 1'b1, 4'd1, 72'hBF},
		'{FUNC_STR,     1'b0, 64'd0, 64'd0, 32'd32, 8'h00, 1'b1, 4'd2, 72'hD920},
		'{FUNC_STR,     1'b0, 64'd0, 64'd0, 32'h1_0000, 8'h00, 1'b1, 4'd5, 72'hDB00010000},
		'{FUNC_BIN,     1'b0, 64'd0, 64'd0, 32'd0, 8'h00, 1'b1, 4'd2, 72'hC400},
		'{FUNC_BIN,     1'b0, 64'd0, 64'd0, '1, 8'h00, 1'b1, 4'd5, 72'hC6FFFFFFFF},
		'{FUNC_ARRAY,   1'b0, 64'd0, 64'd0, 32'd16, 8'h00, 1'b1, 4'd3, 72'hDC0010},
		'{FUNC_MAP,     1'b0, 64'd0, 64'd0, 32'd15, 8'h00, 1'b1, 4'd1, 72'h8F},
		'{FUNC_MAP,     1'b0, 64'd0, 64'd0, 32'h1_0000, 8'h00, 1'b0, 4'd0, 72'h0},
		'{FUNC_PAYLOAD, 1'b1, ONES, ONES, '1, 8'hFF, 1'b1, 4'd1, 72'hFF},
		// spare kind at the low end of the range: silent
		'{FUNC_SPARE_LO, 1'b0, ONES, ONES, '1, 8'hFF, 1'b1, 4'd0, 72'h0}
	};

	task automatic run_directed();
		dir_row_t r;
		enc_byte_t e;
		for (int i = 0; i < N_DIR; i++) begin
			r = dir_tbl[i];
			drive_item(r.func, r.flag, r.ival, r.fbits, r.cnt, r.dbyte);
			if (r.lit_ok) begin
				for (int k = r.n_lit - 1; k >= 0; k--) begin
					e.val = r.lit[k*8 +: 8];
					e.tail = (k == 0);
					enc_q = {enc_q, e};
				end
			end else
				encode_token(r.func, r.flag, r.ival, r.fbits, r.cnt, r.dbyte);
		end
		// top spare kind with everything clear
		issue(FUNC_SPARE_HI, 1'b0, 64'd0, 64'd0, 32'd0, 8'h00);
	endtask

	// ---------------------------------------------------------------
	// Random items: mostly well-formed headers with their bodies
	// ---------------------------------------------------------------
	task automatic run_random();
		int sent;
		int pick;
		int n;
		bit paused;
		logic [3:0] f;
		logic [63:0] v;
		sent = 0;
		paused = 0;
		while (sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// string or binary with its full body
				f = $urandom_range(0, 1) ? FUNC_STR : FUNC_BIN;
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				issue(f, 1'($urandom), rand64(), rand64(), n, 8'($urandom));
				repeat (n) issue(FUNC_PAYLOAD, 1'($urandom), rand64(), rand64(), $urandom,
					8'($urandom));
				sent += n + 1;
			end else if (pick < 47) begin
				f = $urandom_range(0, 1) ? FUNC_ARRAY : FUNC_MAP;
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 300) : $urandom_range(0, 17);
				issue(f, 1'($urandom), rand64(), rand64(), n, 8'($urandom));
				sent++;
			end else if (pick < 82) begin
				// scalars; ints spread over every width band and sign
				v = rand64() >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = ~v;
				case ($urandom_range(0, 5))
					0:       f = FUNC_NIL;
					1:       f = FUNC_BOOL;
					2:       f = FUNC_DOUBLE;
					default: f = FUNC_INT;
				endcase
				issue(f, 1'($urandom), v, rand64(), $urandom, 8'($urandom));
				sent++;
			end else if (pick < 89) begin
				// broken: body cut short
				n = $urandom_range(2, 10);
				issue(FUNC_STR, 1'($urandom), rand64(), rand64(), n, 8'($urandom));
				n = $urandom_range(0, n - 1);
				repeat (n) issue(FUNC_PAYLOAD, 1'($urandom), rand64(), rand64(), $urandom,
					8'($urandom));
				sent += n + 1;
			end else if (pick < 95) begin
				// headers with wide counts
				case ($urandom_range(0, 3))
					0:       f = FUNC_STR;
					1:       f = FUNC_BIN;
					2:       f = FUNC_ARRAY;
					default: f = FUNC_MAP;
				endcase
				issue(f, 1'($urandom), rand64(), rand64(), $urandom >> $urandom_range(0, 31),
					8'($urandom));
				sent++;
			end else begin
				// spare kind: ignored, not counted
				f = 4'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
				issue(f, 1'($urandom), rand64(), rand64(), $urandom, 8'($urandom));
			end
			if (!paused && sent >= RAND_ITEMS / 2) begin
				drain();
				paused = 1;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver: its own stall pattern, mode set by rx_phase[7:6], a count of clock cycles
	// ---------------------------------------------------------------
	logic [7:0] rx_phase = '0;

	always @(negedge clk) begin
		rx_phase <= rx_phase + 8'd1;
		case (rx_phase[7:6])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= ($urandom_range(0, 9) < 3);
			default: m_tready <= (rx_phase[1:0] != 2'b11);
		endcase
	end

	// ---------------------------------------------------------------
	// Checker and cycle limit
	// ---------------------------------------------------------------
	int n_fail = 0;
	int n_cyc = 0;

	always @(posedge clk) begin
		enc_byte_t e;
		n_cyc <= n_cyc + 1;
		if (n_cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still owed", n_cyc, enc_q.size());
			$display("TEST FAILED");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			if (enc_q.size() == 0) begin
				if (n_fail < 10)
					$display("%t: byte %02h last %b with nothing owed", $realtime, m_tdata,
						m_tlast);
				n_fail <= n_fail + 1;
			end else begin
				e = enc_q.pop_front();
				if (m_tdata !== e.val || m_tlast !== e.tail) begin
					if (n_fail < 10)
						$display("%t: expected byte %02h last %b, got %02h last %b", $realtime,
							e.val, e.tail, m_tdata, m_tlast);
					n_fail <= n_fail + 1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		drain();
		run_random();
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
